/* hdl/med_pkg.sv */
package med_pkg;

  localparam int MaxElements = 6;
  localparam int CntW        = $clog2(MaxElements + 1);
  localparam int TimeW       = 32;
  localparam int AvgW        = 20;
  localparam int ToutW       = 24;
  localparam int CharW       = 7;

  localparam logic [ToutW-1:0] TimeoutReset = ToutW'(500000);
  localparam logic [2:0]       WordGapDits  = 3'd7;
  localparam logic [CharW-1:0] ChUnknown    = 7'h3f;
  localparam logic [CharW-1:0] ChSpace      = 7'h20;

  typedef enum logic [2:0] {
    OP_DIT      = 3'd0,
    OP_DAH      = 3'd1,
    OP_INTRA    = 3'd2,
    OP_CHAR_GAP = 3'd3,
    OP_WORD_GAP = 3'd4,
    OP_UNKNOWN  = 3'd5,
    OP_TICK     = 3'd6
  } med_op_e;

  typedef enum logic {
    REG_ENABLED = 1'b0,
    REG_TIMEOUT = 1'b1
  } med_reg_e;

  typedef struct packed {
    logic [2:0]       op;
    logic [TimeW-1:0] time_us;
    logic [AvgW-1:0]  dit_len_avg;
  } med_item_t;

  typedef struct packed {
    logic             emit;
    logic [CharW-1:0] ch;
    logic             space;
  } med_res_t;

  // ITU table; pattern is MSB-first, dah = 1
  function automatic logic [CharW-1:0] lookup_char(input logic [3:0] count,
                                                   input logic [7:0] bits);
    logic [CharW-1:0] c;
    c = ChUnknown;
    case (count)
      4'd1: begin
        case (bits)
          8'b0: c = 7'h45; // E
          8'b1: c = 7'h54; // T
          default: c = ChUnknown;
        endcase
      end
      4'd2: begin
        case (bits)
          8'b00: c = 7'h49; // I
          8'b01: c = 7'h41; // A
          8'b10: c = 7'h4e; // N
          8'b11: c = 7'h4d; // M
          default: c = ChUnknown;
        endcase
      end
      4'd3: begin
        case (bits)
          8'b000: c = 7'h53; // S
          8'b001: c = 7'h55; // U
          8'b010: c = 7'h52; // R
          8'b011: c = 7'h57; // W
          8'b100: c = 7'h44; // D
          8'b101: c = 7'h4b; // K
          8'b110: c = 7'h47; // G
          8'b111: c = 7'h4f; // O
          default: c = ChUnknown;
        endcase
      end
      4'd4: begin
        case (bits)
          8'b0000: c = 7'h48; // H
          8'b0001: c = 7'h56; // V
          8'b0010: c = 7'h46; // F
          8'b0100: c = 7'h4c; // L
          8'b0110: c = 7'h50; // P
          8'b0111: c = 7'h4a; // J
          8'b1000: c = 7'h42; // B
          8'b1001: c = 7'h58; // X
          8'b1010: c = 7'h43; // C
          8'b1011: c = 7'h59; // Y
          8'b1100: c = 7'h5a; // Z
          8'b1101: c = 7'h51; // Q
          default: c = ChUnknown;
        endcase
      end
      4'd5: begin
        case (bits)
          8'b11111: c = 7'h30;
          8'b01111: c = 7'h31;
          8'b00111: c = 7'h32;
          8'b00011: c = 7'h33;
          8'b00001: c = 7'h34;
          8'b00000: c = 7'h35;
          8'b10000: c = 7'h36;
          8'b11000: c = 7'h37;
          8'b11100: c = 7'h38;
          8'b11110: c = 7'h39;
          8'b10010: c = 7'h2f; // /
          8'b10110: c = 7'h28; // (
          8'b10001: c = 7'h3d; // =
          8'b01010: c = 7'h2b; // +
          default:  c = ChUnknown;
        endcase
      end
      4'd6: begin
        case (bits)
          8'b010101: c = 7'h2e; // .
          8'b110011: c = 7'h2c; // ,
          8'b111000: c = 7'h3a; // :
          8'b001100: c = ChUnknown;
          8'b011110: c = 7'h27; // '
          8'b100001: c = 7'h2d; // -
          8'b101101: c = 7'h29; // )
          8'b010010: c = 7'h22; // "
          8'b011010: c = 7'h40; // @
          default:   c = ChUnknown;
        endcase
      end
      default: c = ChUnknown;
    endcase
    return c;
  endfunction

endpackage

/* hdl/med_core.sv */
module med_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    fire_i,
  input  med_pkg::med_item_t      item_i,
  input  logic                    enabled_i,
  input  logic [med_pkg::ToutW-1:0] timeout_i,
  output med_pkg::med_res_t       res_o
);
  import med_pkg::*;

  logic                   recv_q, recv_d;
  logic [MaxElements-1:0] bits_q, bits_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [TimeW-1:0]       last_time_q, last_time_d;

  logic [TimeW-1:0] elapsed;
  logic [TimeW-1:0] limit;
  logic [AvgW+2:0]  avg_x7;
  logic [CharW-1:0] decoded;

  assign avg_x7  = ({3'b000, item_i.dit_len_avg} << 3) - {3'b000, item_i.dit_len_avg};
  assign limit   = (item_i.dit_len_avg != '0) ? TimeW'(avg_x7) : TimeW'(timeout_i);
  assign elapsed = item_i.time_us - last_time_q;
  assign decoded = lookup_char(4'(cnt_q), 8'(bits_q));

  always_comb begin
    recv_d      = recv_q;
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    last_time_d = last_time_q;
    res_o       = '0;
    if (enabled_i) begin
      case (med_op_e'(item_i.op))
        OP_DIT, OP_DAH: begin
          last_time_d = item_i.time_us;
          if (recv_q && cnt_q >= CntW'(MaxElements)) begin
            // element overflow: '?' alone, back to idle
            recv_d   = 1'b0;
            bits_d   = '0;
            cnt_d    = '0;
            res_o.emit = 1'b1;
            res_o.ch   = ChUnknown;
          end else begin
            bits_d = {bits_q[MaxElements-2:0], item_i.op == OP_DAH};
            cnt_d  = cnt_q + CntW'(1);
            recv_d = 1'b1;
          end
        end
        OP_CHAR_GAP, OP_WORD_GAP, OP_TICK: begin
          if (recv_q && (item_i.op != OP_TICK || elapsed >= limit)) begin
            recv_d      = 1'b0;
            bits_d      = '0;
            cnt_d       = '0;
            res_o.emit  = 1'b1;
            res_o.ch    = decoded;
            res_o.space = item_i.op != OP_CHAR_GAP;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recv_q      <= 1'b0;
      bits_q      <= '0;
      cnt_q       <= '0;
      last_time_q <= '0;
    end else if (fire_i) begin
      recv_q      <= recv_d;
      bits_q      <= bits_d;
      cnt_q       <= cnt_d;
      last_time_q <= last_time_d;
    end
  end

endmodule

/* hdl/morse_element_decoder_unit.sv */
// Channel   Handshake              Payload
// in        in_valid_i/in_ready_o  op_i, time_us_i, dit_len_avg_i
// out       out_valid_o/out_ready_i char_code_o, last_o
// cfg       cfg_we_i               cfg_idx_i, cfg_data_i
//
// One in transaction per cycle unless a result waits for the output slot;
// items, then results, are registered. Word ends give two out transactions
// from the single output register; later results wait for the space.
// Reset (rst_ni low, async): idle, empty pattern, enabled, timeout 500000.
// A stalled output stops processing only for items that give a result.
module morse_element_decoder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [2:0]                  op_i,
  input  logic [med_pkg::TimeW-1:0]   time_us_i,
  input  logic [med_pkg::AvgW-1:0]    dit_len_avg_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [med_pkg::CharW-1:0]   char_code_o,
  output logic                        last_o,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [med_pkg::ToutW-1:0]   cfg_data_i
);
  import med_pkg::*;

  logic             enabled_q;
  logic [ToutW-1:0] timeout_q;

  logic             in_valid_q;
  med_item_t        item_q;

  logic             out_valid_q;
  logic [CharW-1:0] char_q;
  logic             last_q;
  logic             space_q;

  med_res_t         res;
  logic             out_free;
  logic             fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b1;
      timeout_q <= TimeoutReset;
    end else if (cfg_we_i) begin
      case (med_reg_e'(cfg_idx_i))
        REG_ENABLED: enabled_q <= cfg_data_i[0];
        REG_TIMEOUT: timeout_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // output slot can take new results this cycle
  assign out_free   = !out_valid_q || (out_ready_i && !space_q);
  assign fire       = in_valid_q && (!res.emit || out_free);
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= '{op: op_i, time_us: time_us_i, dit_len_avg: dit_len_avg_i};
    end
  end

  med_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (item_q),
    .enabled_i (enabled_q),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      space_q     <= 1'b0;
    end else if (fire && res.emit) begin
      out_valid_q <= 1'b1;
      space_q     <= res.space;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_q <= space_q;
      space_q     <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.emit) begin
      char_q <= res.ch;
      last_q <= !res.space;
    end else if (out_valid_q && out_ready_i && space_q) begin
      char_q <= ChSpace;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  a_space_needs_slot: assert property (
    @(posedge clk_i) disable iff (!rst_ni) space_q |-> out_valid_q
  ) else $error("space pending without a held result");

  a_space_follows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=>
      (out_valid_o && last_o && char_code_o == ChSpace)
  ) else $error("word end not followed by a space");

  a_no_emit_disabled: assert property (
    @(posedge clk_i) disable iff (!rst_ni) !enabled_q |-> !(fire && res.emit)
  ) else $error("result produced while disabled");

endmodule

/* sim/tb_morse_element_decoder_unit.sv */
module tb_morse_element_decoder_unit;
  import med_pkg::*;

  localparam logic [2:0]      OpSpare    = 3'd7;
  localparam logic [AvgW-1:0] AvgMax     = '1;
  localparam int              StuckLimit = 2000;
  localparam int              TailCycles = 8;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic [CharW-1:0] char_code;
    logic             last;
  } due_char_t;

  // Tracks the decoder's pattern state and queues the characters it must emit.
  class decoded_char_sb;
    logic [CharW-1:0] itu_code [logic [10:0]];
    bit               receiving;
    logic [7:0]       pattern;
    int unsigned      n_elems;
    logic [TimeW-1:0] last_key_time;
    bit               dec_enabled;
    logic [ToutW-1:0] idle_limit_us;
    due_char_t        chars_due [$];
    int unsigned      mismatches;

    function new();
      add(".-", "A");    add("-...", "B");   add("-.-.", "C");   add("-..", "D");
      add(".", "E");     add("..-.", "F");   add("--.", "G");    add("....", "H");
      add("..", "I");    add(".---", "J");   add("-.-", "K");    add(".-..", "L");
      add("--", "M");    add("-.", "N");     add("---", "O");    add(".--.", "P");
      add("--.-", "Q");  add(".-.", "R");    add("...", "S");    add("-", "T");
      add("..-", "U");   add("...-", "V");   add(".--", "W");    add("-..-", "X");
      add("-.--", "Y");  add("--..", "Z");
      add("-----", "0"); add(".----", "1");  add("..---", "2");  add("...--", "3");
      add("....-", "4"); add(".....", "5");  add("-....", "6");  add("--...", "7");
      add("---..", "8"); add("----.", "9");
      add(".-.-.-", "."); add("--..--", ","); add("---...", ":"); add("..--..", "?");
      add(".----.", "'"); add("-....-", "-"); add("-..-.", "/");  add("-.--.", "(");
      add("-.--.-", ")"); add(".-..-.", "\""); add("-...-", "="); add(".-.-.", "+");
      add(".--.-.", "@");
      dec_enabled   = 1'b1;
      idle_limit_us = TimeoutReset;
      last_key_time = '0;
      mismatches    = 0;
      clear_pattern();
    endfunction

    // key is {element count, elements with the first one in the MSB, dah = 1}
    function void add(string pat, byte ch);
      logic [7:0] bits;
      bits = '0;
      for (int i = 0; i < pat.len(); i++) bits = {bits[6:0], pat[i] == "-"};
      itu_code[{3'(pat.len()), bits}] = ch[CharW-1:0];
    endfunction

    function void clear_pattern();
      receiving = 1'b0;
      pattern   = '0;
      n_elems   = 0;
    endfunction

    function void close_char(bit with_space);
      logic [10:0] key;
      key = {3'(n_elems), pattern};
      chars_due.insert(chars_due.size(),
                       '{itu_code.exists(key) ? itu_code[key] : ChUnknown, !with_space});
      if (with_space) chars_due.insert(chars_due.size(), '{ChSpace, 1'b1});
      clear_pattern();
    endfunction

    function void set_reg(med_reg_e idx, logic [ToutW-1:0] data);
      if (idx == REG_ENABLED) dec_enabled = data[0];
      else idle_limit_us = data;
    endfunction

    function void note_event(logic [2:0] op, logic [TimeW-1:0] t, logic [AvgW-1:0] avg);
      logic [TimeW-1:0] limit;
      logic [TimeW-1:0] elapsed;
      if (!dec_enabled) return;
      if (op == OP_DIT || op == OP_DAH) begin
        last_key_time = t;
        if (receiving && n_elems >= MaxElements) begin
          clear_pattern();
          chars_due.insert(chars_due.size(), '{ChUnknown, 1'b1});
          return;
        end
        pattern = {pattern[6:0], op == OP_DAH};
        n_elems++;
        receiving = 1'b1;
        return;
      end
      if (!receiving) return;
      case (op)
        OP_CHAR_GAP: close_char(1'b0);
        OP_WORD_GAP: close_char(1'b1);
        OP_TICK: begin
          limit   = (avg != 0) ? 32'(avg) * 32'(WordGapDits) : 32'(idle_limit_us);
          elapsed = t - last_key_time;
          if (elapsed >= limit) close_char(1'b1);
        end
        default: ;
      endcase
    endfunction

    function void check_char(logic [CharW-1:0] ch, logic lst);
      due_char_t exp_c;
      if (chars_due.size() == 0) begin
        $error("unexpected result transaction: char_code %h last %b", ch, lst);
        mismatches++;
        return;
      end
      exp_c = chars_due[0];
      chars_due.delete(0);
      if (ch !== exp_c.char_code) begin
        $error("char_code expected %h actual %h", exp_c.char_code, ch);
        mismatches++;
      end
      if (lst !== exp_c.last) begin
        $error("last expected %b actual %b", exp_c.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic [2:0]        op_i          = '0;
  logic [TimeW-1:0]  time_us_i     = '0;
  logic [AvgW-1:0]   dit_len_avg_i = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [CharW-1:0]  char_code_o;
  logic              last_o;
  logic              cfg_we_i      = 1'b0;
  logic              cfg_idx_i     = 1'b0;
  logic [ToutW-1:0]  cfg_data_i    = '0;

  decoded_char_sb    sb;
  logic [TimeW-1:0]  now_us          = '0;
  logic [ToutW-1:0]  timeout_setting = TimeoutReset;
  int unsigned       sent            = 0;
  int unsigned       in_idle_pct     = 0;
  int unsigned       out_stall_pct   = 0;
  int unsigned       stuck_cycles    = 0;

  morse_element_decoder_unit u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= out_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_char(char_code_o, last_o);
      if (in_valid_i && in_ready_o) sb.note_event(op_i, time_us_i, dit_len_avg_i);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == StuckLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SENDER:   begin in_idle_pct = 75; out_stall_pct = 0;  end
      IDLE_RECEIVER: begin in_idle_pct = 0;  out_stall_pct = 75; end
      IDLE_BOTH:     begin in_idle_pct = 29; out_stall_pct = 29; end
      default:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
    endcase
  endtask

  task automatic send_item(logic [2:0] op, logic [TimeW-1:0] t, logic [AvgW-1:0] avg);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    op_i          <= op;
    time_us_i     <= t;
    dit_len_avg_i <= avg;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    now_us = t;
    sent++;
  endtask

  // drop valid and wait out every pending character plus the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.chars_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(med_reg_e idx, logic [ToutW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    if (idx == REG_TIMEOUT) timeout_setting = data;
  endtask

  task automatic run_directed();
    send_item(OP_DIT, 32'd0, '0);
    send_item(OP_CHAR_GAP, 32'd10, '0);
    send_item(OP_DAH, 32'd20, AvgMax);
    send_item(OP_WORD_GAP, 32'd30, AvgMax);
    // six elements fill the pattern, the seventh overflows it
    for (int i = 0; i < MaxElements + 1; i++)
      send_item((i % 2) ? OP_DAH : OP_DIT, 32'd40 + 32'(i), '0);
    // idle: gaps, ticks and unused codes do nothing
    send_item(OP_INTRA, 32'd50, '0);
    send_item(OP_CHAR_GAP, 32'd51, '0);
    send_item(OP_WORD_GAP, 32'd52, '0);
    send_item(OP_TICK, '1, 20'd1);
    send_item(OP_UNKNOWN, 32'd53, '0);
    send_item(OpSpare, 32'd54, '0);
    // elapsed time across the 32-bit wrap
    send_item(OP_DIT, 32'hFFFF_FFF0, '0);
    send_item(OP_UNKNOWN, 32'h0000_0000, '0);
    send_item(OP_TICK, 32'h0000_0010, 20'd1);
    // largest average: just below the limit, then at it
    send_item(OP_DAH, 32'd1000, '0);
    send_item(OP_TICK, 32'd1000 + 32'(AvgMax) * 32'(WordGapDits) - 32'd1, AvgMax);
    send_item(OP_TICK, 32'd1000 + 32'(AvgMax) * 32'(WordGapDits), AvgMax);
    // no average known: default timeout boundary
    send_item(OP_DIT, 32'd5000, '0);
    send_item(OP_TICK, 32'd5000 + 32'(TimeoutReset) - 32'd1, '0);
    send_item(OP_TICK, 32'd5000 + 32'(TimeoutReset), '0);
  endtask

  task automatic send_symbol();
    int unsigned      n;
    logic [TimeW-1:0] key_t;
    logic [TimeW-1:0] limit;
    logic [TimeW-1:0] gap;
    logic [AvgW-1:0]  avg;
    n = ($urandom_range(99) < 8) ? MaxElements + 1 : $urandom_range(MaxElements, 1);
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(1))
        send_item(OP_INTRA, now_us + $urandom_range(200), AvgW'($urandom_range(AvgMax)));
      send_item($urandom_range(1) ? OP_DAH : OP_DIT, now_us + $urandom_range(300),
                AvgW'($urandom_range(AvgMax)));
    end
    key_t = now_us;
    case ($urandom_range(3))
      0: send_item(OP_CHAR_GAP, now_us + $urandom_range(500), AvgW'($urandom_range(AvgMax)));
      1: send_item(OP_WORD_GAP, now_us + $urandom_range(500), AvgW'($urandom_range(AvgMax)));
      2: begin
        case ($urandom_range(3))
          0:       avg = '0;
          1:       avg = AvgW'($urandom_range(50, 1));
          2:       avg = AvgMax;
          default: avg = AvgW'($urandom_range(AvgMax));
        endcase
        limit = (avg != 0) ? 32'(avg) * 32'(WordGapDits) : 32'(timeout_setting);
        if (limit != 0 && $urandom_range(1)) begin
          gap = $urandom_range(1) ? limit - 32'd1 : 32'($urandom_range(limit - 32'd1));
          send_item(OP_TICK, key_t + gap, avg);
        end
        send_item(OP_TICK, key_t + limit + $urandom_range(3), avg);
      end
      default: begin
        send_item(OP_TICK, $urandom(), AvgW'($urandom_range(AvgMax)));
        send_item(OP_CHAR_GAP, now_us + $urandom_range(500), '0);
      end
    endcase
  endtask

  task automatic run_traffic(int unsigned n_items);
    int unsigned goal;
    goal = sent + n_items;
    while (sent < goal) begin
      if ($urandom_range(99) < 80) send_symbol();
      else send_item(3'($urandom_range(7)), $urandom(),
                     $urandom_range(1) ? '0 : AvgW'($urandom_range(AvgMax)));
    end
  endtask

  initial begin
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_idling(IDLE_NONE);
    run_directed();
    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: ;
        1: write_reg(REG_TIMEOUT, '0);
        2: write_reg(REG_TIMEOUT, '1);
        3: write_reg(REG_ENABLED, 24'd0);
        4: begin
          write_reg(REG_ENABLED, 24'd1);
          write_reg(REG_TIMEOUT, 24'd1);
        end
        5: write_reg(REG_TIMEOUT, TimeoutReset);
        default: write_reg(REG_TIMEOUT, ToutW'($urandom_range(24'hFF_FFFF, 1)));
      endcase
      set_idling(idle_mode_e'(p % 4));
      run_traffic((p == 3) ? 40 : 200);
    end
    settle();
    if (sb.mismatches == 0 && sb.chars_due.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

/* morse_element_decoder_unit.f */
hdl/med_pkg.sv
hdl/med_core.sv
hdl/morse_element_decoder_unit.sv
sim/tb_morse_element_decoder_unit.sv
